@@ hw/rtl/etr_pkg.sv @@
// Package for the ESC throttle ramp: widths, register indexes, reset values, opcodes, states, phase codes.
`default_nettype none

package etr_pkg;

  // Pulse width in microseconds
  localparam int PULSE_BITS = 12;
  localparam int SPEED_W    = 8;
  localparam int STEP_W     = 6;
  localparam int SETTLE_W   = 10;
  localparam int CFG_IDX_W  = 2;

  // speed * |span|, and the width of the reciprocal estimate sum
  localparam int MAG_W = SPEED_W + PULSE_BITS;
  localparam int EST_W = MAG_W + 17;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICK = 2'd3;

  // Reset values
  localparam logic [STEP_W-1:0]     RST_STEP_SIZE = STEP_W'(2);
  localparam logic [PULSE_BITS-1:0] RST_MIN_PULSE = PULSE_BITS'(1000);
  localparam logic [PULSE_BITS-1:0] RST_MAX_PULSE = PULSE_BITS'(2000);
  localparam logic [SETTLE_W-1:0]   RST_SETTLE    = SETTLE_W'(100);

  // Opcodes carried in tuser
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  // Ramp sequencer states
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_BRAKE  = 4'b0010,
    PH_SETTLE = 4'b0100,
    PH_RAMP   = 4'b1000
  } phase_t;

  // Phase codes as reported on the result stream
  localparam logic [1:0] PHC_IDLE   = 2'd0;
  localparam logic [1:0] PHC_BRAKE  = 2'd1;
  localparam logic [1:0] PHC_SETTLE = 2'd2;
  localparam logic [1:0] PHC_RAMP   = 2'd3;

endpackage

`default_nettype wire

@@ hw/rtl/esc_throttle_ramp_with_reversal_unit.sv @@
// ESC throttle slew limiter with reverse interlock: pipeline, sequencer and config registers.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in_     | slave     | in_tvalid/tready   | tuser opcode, tdata speed + direction
//  out_    | master    | out_tvalid/tready  | tdata pulse, relay, phase
//  cfg_    | slave     | cfg_valid/ready    | cfg_index, cfg_data (always ready)
//
// One request per cycle sustained while out_tready is high; three register stages (stage 1,
// stage 2, result register) lie between the accepting edge and out_tvalid rising.
// Stage 1 registers speed * |max - min|, stage 2 divides by 255 through a reciprocal
// shift-add with one correction step, stage 3 updates the ramp state and the result.
// Reset (rst_n low, synchronous) loads the default registers and a forward, idle state.
// Stages hold when downstream is full and stalled; an empty stage takes a request anyway.
`default_nettype none

module esc_throttle_ramp_with_reversal_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // in_tuser: [0] opcode
  // in_tdata: [7:0] target_speed, [8] want_reverse, [15:9] zero
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [15:0]                    in_tdata,
  input  wire logic                           in_tuser,
  // out_tdata: [11:0] esc_pulse_us, [12] relay_reverse, [14:13] ramp_phase, [15] zero
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [15:0]                         out_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [etr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [etr_pkg::PULSE_BITS-1:0] cfg_data
);
  import etr_pkg::*;

  // Configuration registers
  logic [STEP_W-1:0]     step_r;
  logic [PULSE_BITS-1:0] min_r;
  logic [PULSE_BITS-1:0] max_r;
  logic [SETTLE_W-1:0]   settle_ticks_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r         <= RST_STEP_SIZE;
      min_r          <= RST_MIN_PULSE;
      max_r          <= RST_MAX_PULSE;
      settle_ticks_r <= RST_SETTLE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STEP_SIZE:   step_r         <= cfg_data[STEP_W-1:0];
        CFG_MIN_PULSE:   min_r          <= cfg_data;
        CFG_MAX_PULSE:   max_r          <= cfg_data;
        CFG_SETTLE_TICK: settle_ticks_r <= cfg_data[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when empty or when it empties this cycle
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_move, s2_rdy, s1_rdy;

  assign out_move  = out_tready || !out_v_r;
  assign s2_rdy    = !s2_v_r || out_move;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_tready = s1_rdy;

  logic in_acc, s1_to_s2, s2_to_out;
  assign in_acc    = in_tvalid && in_tready;
  assign s1_to_s2  = s1_v_r && s2_rdy;
  assign s2_to_out = s2_v_r && out_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy)   s1_v_r  <= in_acc;
      if (s2_rdy)   s2_v_r  <= s1_to_s2;
      if (out_move) out_v_r <= s2_v_r;
    end
  end

  // Stage 1: signed span and magnitude product
  logic [PULSE_BITS:0]   span;
  logic                  span_neg;
  logic [PULSE_BITS-1:0] span_abs;
  logic [MAG_W-1:0]      mag_nxt;

  always_comb begin
    span     = {1'b0, max_r} - {1'b0, min_r};
    span_neg = span[PULSE_BITS];
    span_abs = span_neg ? PULSE_BITS'(-span) : span[PULSE_BITS-1:0];
    mag_nxt  = MAG_W'(in_tdata[SPEED_W-1:0]) * MAG_W'(span_abs);
  end

  logic             s1_op_r, s1_rev_r, s1_neg_r;
  logic [MAG_W-1:0] s1_mag_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_tuser;
      s1_rev_r <= in_tdata[SPEED_W];
      s1_neg_r <= span_neg;
      s1_mag_r <= mag_nxt;
    end
  end

  // Stage 2: divide by 255 (estimate by 1/255 = 65793 / 2^24, then one correction)
  logic [EST_W-1:0]      est_sum;
  logic [PULSE_BITS-1:0] est;
  logic [MAG_W-1:0]      est_x255, rem;
  logic [PULSE_BITS-1:0] quot;
  logic [PULSE_BITS-1:0] tgt_nxt;

  always_comb begin
    est_sum  = EST_W'(s1_mag_r) + (EST_W'(s1_mag_r) << 8) + (EST_W'(s1_mag_r) << 16);
    est      = est_sum[24 +: PULSE_BITS];
    est_x255 = (MAG_W'(est) << 8) - MAG_W'(est);
    rem      = s1_mag_r - est_x255;
    quot     = (rem >= MAG_W'(255)) ? est + PULSE_BITS'(1) : est;
    tgt_nxt  = s1_neg_r ? min_r - quot : min_r + quot;
  end

  logic                  s2_op_r, s2_rev_r;
  logic [PULSE_BITS-1:0] s2_tgt_r;

  always_ff @(posedge clk) begin
    if (s1_to_s2) begin
      s2_op_r  <= s1_op_r;
      s2_rev_r <= s1_rev_r;
      s2_tgt_r <= tgt_nxt;
    end
  end

  // Stage 3: ramp sequencer state
  logic [PULSE_BITS-1:0] pulse_r, pulse_nxt;
  logic [PULSE_BITS-1:0] final_r, final_nxt;
  logic                  dir_now_r, dir_now_nxt;
  logic                  dir_want_r, dir_want_nxt;
  phase_t                phase_r, phase_nxt;
  logic [SETTLE_W-1:0]   settle_r, settle_nxt;

  // One step toward goal, landing exactly on it
  function automatic logic [PULSE_BITS-1:0] move_toward(
    input logic [PULSE_BITS-1:0] cur,
    input logic [PULSE_BITS-1:0] goal,
    input logic [STEP_W-1:0]     st
  );
    logic [PULSE_BITS-1:0] stx;
    logic [PULSE_BITS-1:0] res;
    stx = PULSE_BITS'(st);
    res = cur;
    if (cur < goal) begin
      res = ((goal - cur) <= stx) ? goal : cur + stx;
    end else if (cur > goal) begin
      res = ((cur - goal) <= stx) ? goal : cur - stx;
    end
    return res;
  endfunction

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] c;
    unique case (ph)
      PH_IDLE:   c = PHC_IDLE;
      PH_BRAKE:  c = PHC_BRAKE;
      PH_SETTLE: c = PHC_SETTLE;
      PH_RAMP:   c = PHC_RAMP;
      default:   c = PHC_IDLE;
    endcase
    return c;
  endfunction

  logic [STEP_W-1:0]   step_eff;
  logic [SETTLE_W-1:0] settle_dec;

  always_comb begin
    // a step size of zero moves by one
    step_eff     = (step_r == '0) ? STEP_W'(1) : step_r;
    pulse_nxt    = pulse_r;
    final_nxt    = final_r;
    dir_now_nxt  = dir_now_r;
    dir_want_nxt = dir_want_r;
    phase_nxt    = phase_r;
    settle_nxt   = settle_r;
    settle_dec   = (settle_r != '0) ? settle_r - SETTLE_W'(1) : settle_r;

    if (s2_op_r == OP_COMMAND) begin
      final_nxt    = s2_tgt_r;
      dir_want_nxt = s2_rev_r;
      if (s2_rev_r != dir_now_r) begin
        phase_nxt = PH_BRAKE;
      end else if (phase_r != PH_SETTLE) begin
        phase_nxt = (pulse_r == s2_tgt_r) ? PH_IDLE : PH_RAMP;
      end
    end else begin
      unique case (phase_r)
        PH_BRAKE: begin
          pulse_nxt = move_toward(pulse_r, min_r, step_eff);
          // at the floor: flip the relay and start settling
          if (pulse_nxt == min_r) begin
            dir_now_nxt = dir_want_r;
            settle_nxt  = settle_ticks_r;
            phase_nxt   = PH_SETTLE;
          end
        end
        PH_SETTLE: begin
          settle_nxt = settle_dec;
          if (settle_dec == '0) begin
            phase_nxt = (pulse_r == final_r) ? PH_IDLE : PH_RAMP;
          end
        end
        PH_RAMP: begin
          pulse_nxt = move_toward(pulse_r, final_r, step_eff);
          if (pulse_nxt == final_r) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_IDLE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r    <= RST_MIN_PULSE;
      final_r    <= RST_MIN_PULSE;
      dir_now_r  <= 1'b0;
      dir_want_r <= 1'b0;
      phase_r    <= PH_IDLE;
      settle_r   <= '0;
    end else if (s2_to_out) begin
      pulse_r    <= pulse_nxt;
      final_r    <= final_nxt;
      dir_now_r  <= dir_now_nxt;
      dir_want_r <= dir_want_nxt;
      phase_r    <= phase_nxt;
      settle_r   <= settle_nxt;
    end
  end

  // Result register: snapshot of the state after the request
  logic [PULSE_BITS-1:0] out_pulse_r;
  logic                  out_relay_r;
  logic [1:0]            out_phase_r;

  always_ff @(posedge clk) begin
    if (s2_to_out) begin
      out_pulse_r <= pulse_nxt;
      out_relay_r <= dir_now_nxt;
      out_phase_r <= phase_code(phase_nxt);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_phase_r, out_relay_r, out_pulse_r};

  // Idle means the pulse sits on its target
  a_idle_on_target: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> pulse_r == final_r)
    else $error("idle phase with pulse off target");

  // A pending direction change is always being braked
  a_dir_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    dir_now_r != dir_want_r |-> phase_r == PH_BRAKE)
    else $error("direction mismatch outside braking");

  // The pulse only moves when a request leaves stage 2
  a_pulse_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_to_out |=> $stable(pulse_r) && $stable(phase_r))
    else $error("ramp state changed without a request");

  // An accepted request always lands in stage 1
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted request lost at stage 1");

endmodule

`default_nettype wire
